/* src/vrf_pkg.sv */
// Package for the vector refraction core: fixed-point widths, pipeline depth
// and the word types that travel down the square-root cell chain.
// No dependencies.
package vrf_pkg;

  // Component format: signed Q1.14 in, signed Q3.14 out
  localparam int CW    = 16;
  localparam int F     = 14;
  localparam int OUT_W = CW + 2;
  localparam int ONE   = 1 << F;
  localparam int HALF  = 1 << (F - 1);

  // Intermediate widths, each just wide enough for its full range
  localparam int PROD_W = 2 * CW;
  localparam int SUM_W  = 2 * CW + 2;
  localparam int D_W    = SUM_W + 1 - F;
  localparam int DD_W   = 2 * D_W;
  localparam int D2_W   = DD_W + 1 - F;
  localparam int EE_W   = 2 * CW;
  localparam int E2_W   = EE_W + 1 - F;
  localparam int OMD_W  = D2_W + 1;
  localparam int PK_W   = E2_W + 1 + OMD_W;
  localparam int T_W    = PK_W + 1 - F;
  localparam int K_W    = T_W + 1;
  localparam int RAD_W  = K_W - 1 + F;
  localparam int ROOT_W = (RAD_W + 1) / 2;
  localparam int RAD2_W = 2 * ROOT_W;
  localparam int REM_W  = ROOT_W + 2;
  localparam int S_W    = ROOT_W + 1;
  localparam int ETAD_W = CW + 1 + D_W;
  localparam int ED_W   = ETAD_W + 1 - F;
  localparam int M_W    = ((ED_W > S_W + 1) ? ED_W : S_W + 1) + 1;
  localparam int EI_W   = 2 * CW + 1;
  localparam int MN_W   = M_W + CW;
  localparam int V_W    = ((EI_W > MN_W) ? EI_W : MN_W) + 2;
  localparam int R_W    = V_W - F;

  // Pipeline shape
  localparam int FRONT_STAGES = 4;
  localparam int BACK_STAGES  = 2;
  localparam int PIPE_DEPTH   = FRONT_STAGES + ROOT_W + BACK_STAGES;

  // Output clamp values
  localparam logic [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

  // Operands that ride along the square-root chain
  typedef struct packed {
    logic [2:0][CW-1:0] iv;
    logic [2:0][CW-1:0] nv;
    logic [CW-1:0]      eta;
    logic [ED_W-1:0]    ed;
    logic               tir;
  } side_t;

  // One word of the square-root chain
  typedef struct packed {
    logic [RAD2_W-1:0] rad;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
    side_t             side;
  } sqrt_word_t;

endpackage

/* src/vrf_if.sv */
// Valid/ready channel interfaces for the vector refraction core.
// Depends on vrf_pkg for the component widths.
interface vrf_in_if import vrf_pkg::*; ();
  logic          valid;
  logic          ready;
  logic [CW-1:0] incident_x;
  logic [CW-1:0] incident_y;
  logic [CW-1:0] incident_z;
  logic [CW-1:0] normal_x;
  logic [CW-1:0] normal_y;
  logic [CW-1:0] normal_z;
  logic [CW-1:0] index_ratio;

  modport source (output valid, incident_x, incident_y, incident_z,
                  normal_x, normal_y, normal_z, index_ratio, input ready);
  modport sink   (input valid, incident_x, incident_y, incident_z,
                  normal_x, normal_y, normal_z, index_ratio, output ready);
endinterface

interface vrf_out_if import vrf_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OUT_W-1:0] refracted_x;
  logic [OUT_W-1:0] refracted_y;
  logic [OUT_W-1:0] refracted_z;
  logic             total_reflection;
  logic             saturated;

  modport source (output valid, refracted_x, refracted_y, refracted_z,
                  total_reflection, saturated, input ready);
  modport sink   (input valid, refracted_x, refracted_y, refracted_z,
                  total_reflection, saturated, output ready);
endinterface

/* src/vrf_front.sv */
// Front pipeline: dot product, k = 1 - eta^2(1 - d^2) and the radicand.
// Depends on vrf_pkg and vrf_in_if; feeds the first square-root cell.
module vrf_front import vrf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  vrf_in_if.sink      item_i,
  output logic        valid_o,
  input  logic        ready_i,
  output sqrt_word_t  word_o
);

  logic [FRONT_STAGES-1:0] v_q;
  logic [FRONT_STAGES-1:0] en;

  // Stage 1: products
  logic [2:0][CW-1:0]        iv1_q, nv1_q;
  logic [CW-1:0]             eta1_q;
  logic signed [PROD_W-1:0]  pr_q [3];
  logic [EE_W-1:0]           ee_q;

  // Stage 2: d, d*d, eta^2
  logic [2:0][CW-1:0]        iv2_q, nv2_q;
  logic [CW-1:0]             eta2_q;
  logic signed [D_W-1:0]     d_q;
  logic signed [DD_W-1:0]    dd_q;
  logic [E2_W-1:0]           e2_q;
  logic signed [SUM_W:0]     rs_d;
  logic [EE_W:0]             ree_d;

  // Stage 3: eta^2(1 - d^2), eta*d
  logic [2:0][CW-1:0]        iv3_q, nv3_q;
  logic [CW-1:0]             eta3_q;
  logic signed [PK_W-1:0]    pk_q;
  logic signed [ETAD_W-1:0]  etad_q;
  logic signed [DD_W:0]      rdd_d;
  logic signed [D2_W-1:0]    d2_d;
  logic signed [OMD_W-1:0]   omd_d;

  // Stage 4: k, reflection flag, radicand
  sqrt_word_t                word_q;
  logic signed [PK_W:0]      rpk_d;
  logic signed [T_W-1:0]     t_d;
  logic signed [K_W-1:0]     k_d;
  logic signed [ETAD_W:0]    red_d;
  logic                      tir_d;

  // Advance a stage when it is empty or its content moves on
  always_comb begin
    en[FRONT_STAGES-1] = !v_q[FRONT_STAGES-1] || ready_i;
    for (int s = FRONT_STAGES - 2; s >= 0; s--) begin
      en[s] = !v_q[s] || en[s+1];
    end
  end

  assign item_i.ready = en[0];
  assign valid_o      = v_q[FRONT_STAGES-1];
  assign word_o       = word_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= item_i.valid;
      for (int s = 1; s < FRONT_STAGES; s++) begin
        if (en[s]) v_q[s] <= v_q[s-1];
      end
    end
  end

  // Round the sums and build k
  always_comb begin
    rs_d  = (SUM_W+1)'(pr_q[0]) + (SUM_W+1)'(pr_q[1]) + (SUM_W+1)'(pr_q[2])
          + (SUM_W+1)'(HALF);
    ree_d = (EE_W+1)'(ee_q) + (EE_W+1)'(HALF);

    rdd_d = (DD_W+1)'(dd_q) + (DD_W+1)'(HALF);
    d2_d  = rdd_d[DD_W:F];
    omd_d = OMD_W'(ONE) - OMD_W'(d2_d);

    rpk_d = (PK_W+1)'(pk_q) + (PK_W+1)'(HALF);
    t_d   = rpk_d[PK_W:F];
    k_d   = K_W'(ONE) - K_W'(t_d);
    tir_d = k_d[K_W-1];
    red_d = (ETAD_W+1)'(etad_q) + (ETAD_W+1)'(HALF);
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      iv1_q    <= {item_i.incident_z, item_i.incident_y, item_i.incident_x};
      nv1_q    <= {item_i.normal_z, item_i.normal_y, item_i.normal_x};
      eta1_q   <= item_i.index_ratio;
      pr_q[0]  <= $signed(item_i.normal_x) * $signed(item_i.incident_x);
      pr_q[1]  <= $signed(item_i.normal_y) * $signed(item_i.incident_y);
      pr_q[2]  <= $signed(item_i.normal_z) * $signed(item_i.incident_z);
      ee_q     <= item_i.index_ratio * item_i.index_ratio;
    end
    if (en[1]) begin
      iv2_q  <= iv1_q;
      nv2_q  <= nv1_q;
      eta2_q <= eta1_q;
      d_q    <= rs_d[SUM_W:F];
      dd_q   <= $signed(rs_d[SUM_W:F]) * $signed(rs_d[SUM_W:F]);
      e2_q   <= ree_d[EE_W:F];
    end
    if (en[2]) begin
      iv3_q  <= iv2_q;
      nv3_q  <= nv2_q;
      eta3_q <= eta2_q;
      pk_q   <= $signed({1'b0, e2_q}) * omd_d;
      etad_q <= $signed({1'b0, eta2_q}) * d_q;
    end
    if (en[3]) begin
      word_q.rad       <= tir_d ? '0 : RAD2_W'({k_d[K_W-2:0], {F{1'b0}}});
      word_q.rem       <= '0;
      word_q.root      <= '0;
      word_q.side.iv   <= iv3_q;
      word_q.side.nv   <= nv3_q;
      word_q.side.eta  <= eta3_q;
      word_q.side.ed   <= red_d[ETAD_W:F];
      word_q.side.tir  <= tir_d;
    end
  end

endmodule

/* src/vrf_sqrt_cell.sv */
// One square-root cell: settles one root bit from two radicand bits.
// Depends on vrf_pkg for the chain word type.
module vrf_sqrt_cell import vrf_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  output logic       ready_o,
  input  sqrt_word_t word_i,
  output logic       valid_o,
  input  logic       ready_i,
  output sqrt_word_t word_o
);

  logic              valid_q;
  sqrt_word_t        word_q;
  sqrt_word_t        word_d;
  logic [REM_W+1:0]  shifted;
  logic [REM_W+1:0]  trial;
  logic [REM_W+1:0]  diff;
  logic              ge;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign word_o  = word_q;

  // Bring down two radicand bits and try the next root bit
  always_comb begin
    shifted = {word_i.rem, word_i.rad[RAD2_W-1 -: 2]};
    trial   = (REM_W+2)'({word_i.root, 2'b01});
    diff    = shifted - trial;
    ge      = shifted >= trial;

    word_d      = word_i;
    word_d.rad  = {word_i.rad[RAD2_W-3:0], 2'b00};
    word_d.rem  = ge ? diff[REM_W-1:0] : shifted[REM_W-1:0];
    word_d.root = {word_i.root[ROOT_W-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o) word_q <= word_d;
  end

endmodule

/* src/vrf_back.sv */
// Back pipeline: rounds the root, forms eta*i - m*n and saturates the result.
// Depends on vrf_pkg and vrf_out_if; takes the last square-root cell's word.
module vrf_back import vrf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        ready_o,
  input  sqrt_word_t  word_i,
  vrf_out_if.source   result_o
);

  logic                     v1_q, v2_q;
  logic                     en1, en2;
  logic signed [EI_W-1:0]   ei_q [3];
  logic signed [MN_W-1:0]   mn_q [3];
  logic                     tir1_q;
  logic [S_W-1:0]           s_d;
  logic signed [M_W-1:0]    m_d;
  logic signed [V_W-1:0]    v_d [3];
  logic [R_W-1:0]           r_d [3];
  logic [2:0]               hi_d, lo_d;
  logic [OUT_W-1:0]         o_d [3];

  logic [OUT_W-1:0]         rx_q, ry_q, rz_q;
  logic                     tir_q, sat_q;

  assign en2     = !v2_q || result_o.ready;
  assign en1     = !v1_q || en2;
  assign ready_o = en1;

  // Round the root to nearest and form m
  always_comb begin
    s_d = S_W'(word_i.root) + S_W'(word_i.rem > REM_W'(word_i.root));
    m_d = M_W'($signed(word_i.side.ed)) + M_W'(s_d);
  end

  // Round, then clamp each component to the output range
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      v_d[c]  = V_W'(ei_q[c]) - V_W'(mn_q[c]) + V_W'(HALF);
      r_d[c]  = v_d[c][V_W-1:F];
      hi_d[c] = !r_d[c][R_W-1] && (|r_d[c][R_W-2:OUT_W-1]);
      lo_d[c] = r_d[c][R_W-1] && !(&r_d[c][R_W-2:OUT_W-1]);
      o_d[c]  = hi_d[c] ? OUT_MAX : (lo_d[c] ? OUT_MIN : r_d[c][OUT_W-1:0]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (en1) v1_q <= valid_i;
      if (en2) v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      tir1_q <= word_i.side.tir;
      for (int c = 0; c < 3; c++) begin
        ei_q[c] <= $signed({1'b0, word_i.side.eta}) * $signed(word_i.side.iv[c]);
        mn_q[c] <= m_d * $signed(word_i.side.nv[c]);
      end
    end
    if (en2) begin
      rx_q  <= tir1_q ? '0 : o_d[0];
      ry_q  <= tir1_q ? '0 : o_d[1];
      rz_q  <= tir1_q ? '0 : o_d[2];
      tir_q <= tir1_q;
      sat_q <= !tir1_q && (|(hi_d | lo_d));
    end
  end

  assign result_o.valid            = v2_q;
  assign result_o.refracted_x      = rx_q;
  assign result_o.refracted_y      = ry_q;
  assign result_o.refracted_z      = rz_q;
  assign result_o.total_reflection = tir_q;
  assign result_o.saturated        = sat_q;

endmodule

/* src/vector_refract_core.sv */
// Vector refraction core: GLSL-style refract() on Q1.14 vectors, Q3.14 out.
// Depends on vrf_pkg, vrf_if, vrf_front, vrf_sqrt_cell and vrf_back.
//
// The core takes one item per clock and returns one result per item in
// order. Its PIPE_DEPTH stages are four front stages (dot product,
// squares, k and radicand), a chain of 26 square-root cells that each settle
// one root bit, and two back stages (rounding, multiply, saturate). Every
// stage holds its item until the next one is free, so a stall at the output
// only stops the core once all stages are full; bubbles are squeezed out.
// When k is negative the result is the zero vector with total_reflection set.
// The saturated flag marks results in which any component was clamped.
module vector_refract_core import vrf_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  vrf_in_if.sink     item_i,
  vrf_out_if.source  result_o
);

  logic        cv  [ROOT_W+1];
  logic        crd [ROOT_W+1];
  sqrt_word_t  cwd [ROOT_W+1];

  vrf_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .item_i  (item_i),
    .valid_o (cv[0]),
    .ready_i (crd[0]),
    .word_o  (cwd[0])
  );

  // Square-root chain, one root bit per cell
  for (genvar g = 0; g < ROOT_W; g++) begin : g_cell
    vrf_sqrt_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (cv[g]),
      .ready_o (crd[g]),
      .word_i  (cwd[g]),
      .valid_o (cv[g+1]),
      .ready_i (crd[g+1]),
      .word_o  (cwd[g+1])
    );
  end

  vrf_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (cv[ROOT_W]),
    .ready_o  (crd[ROOT_W]),
    .word_i   (cwd[ROOT_W]),
    .result_o (result_o)
  );

endmodule

/* src/vrf_checker.sv */
// Port-level checks for the vector refraction core, bound to its top level.
// Depends on vrf_pkg and the ports of vector_refract_core.
module vrf_checker import vrf_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_i,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input logic [OUT_W-1:0] rx_i,
  input logic [OUT_W-1:0] ry_i,
  input logic [OUT_W-1:0] rz_i,
  input logic             tir_i,
  input logic             sat_i
);

  localparam int CNT_W = $clog2(PIPE_DEPTH + 1) + 1;

  logic [CNT_W-1:0] count_q;
  logic             in_acc, out_acc;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  // Track items inside the core
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_q + CNT_W'(in_acc) - CNT_W'(out_acc);
    end
  end

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> count_q != '0)
    else $error("result shown with no item inside");

  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(PIPE_DEPTH))
    else $error("more items inside than pipeline stages");

  a_tir_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && tir_i |-> rx_i == '0 && ry_i == '0 && rz_i == '0 && !sat_i)
    else $error("total reflection result is not a clean zero vector");

  a_sat_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && sat_i |->
      rx_i == OUT_MAX || rx_i == OUT_MIN || ry_i == OUT_MAX || ry_i == OUT_MIN ||
      rz_i == OUT_MAX || rz_i == OUT_MIN)
    else $error("saturated flag without a clamped component");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      out_valid_i && $stable(rx_i) && $stable(ry_i) && $stable(rz_i) &&
      $stable(tir_i) && $stable(sat_i))
    else $error("stalled result changed");

endmodule

bind vector_refract_core vrf_checker u_vrf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (item_i.valid),
  .in_ready_i  (item_i.ready),
  .out_valid_i (result_o.valid),
  .out_ready_i (result_o.ready),
  .rx_i        (result_o.refracted_x),
  .ry_i        (result_o.refracted_y),
  .rz_i        (result_o.refracted_z),
  .tir_i       (result_o.total_reflection),
  .sat_i       (result_o.saturated)
);

/* sim/tb_vector_refract_core.sv */
// Self-checking bench for vector_refract_core: random and directed refraction
// items, a fixed-point predictor and an in-order result check.
// Depends on vrf_pkg, vrf_if and the core RTL.
module tb_vector_refract_core import vrf_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [CW-1:0] ix, iy, iz, nx, ny, nz, eta;
  } ray_t;

  typedef struct {
    logic [OUT_W-1:0] rx, ry, rz;
    logic             tir, sat;
  } refr_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  ray_t  ray_q[$];
  refr_t refr_q[$];
  int    errors = 0;
  int    cycles = 0;
  bit    stim_done = 1'b0;
  int    hold_cycles = 0;
  int    send_gap = 0;
  int    recv_gap = 0;

  vrf_in_if  item_if ();
  vrf_out_if result_if ();

  vector_refract_core i_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_if.sink),
    .result_o (result_if.source)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Round to nearest, ties up, dropping F fraction bits
  function automatic longint round_fx(longint v);
    return (v + HALF) >>> F;
  endfunction

  // Nearest integer square root
  function automatic longint root_near(longint x);
    longint r, b;
    r = 0;
    b = longint'(1) << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    if (x > r) r++;
    return r;
  endfunction

  function automatic refr_t refract(ray_t t);
    longint iv[3], nv[3], eta, d, d2, e2, k, s, m, v, hi, lo;
    refr_t res;
    logic [OUT_W-1:0] o[3];
    iv[0] = longint'($signed(t.ix)); iv[1] = longint'($signed(t.iy));
    iv[2] = longint'($signed(t.iz));
    nv[0] = longint'($signed(t.nx)); nv[1] = longint'($signed(t.ny));
    nv[2] = longint'($signed(t.nz));
    eta = longint'(t.eta);
    res.sat = 1'b0;
    res.tir = 1'b0;
    d  = round_fx(nv[0]*iv[0] + nv[1]*iv[1] + nv[2]*iv[2]);
    d2 = round_fx(d*d);
    e2 = round_fx(eta*eta);
    k  = ONE - round_fx(e2 * (ONE - d2));
    if (k < 0) begin
      res.rx = '0; res.ry = '0; res.rz = '0;
      res.tir = 1'b1;
      return res;
    end
    s = root_near(k << F);
    m = round_fx(eta*d) + s;
    hi = (longint'(1) << (OUT_W-1)) - 1;
    lo = -(longint'(1) << (OUT_W-1));
    for (int c = 0; c < 3; c++) begin
      v = round_fx(eta*iv[c] - m*nv[c]);
      if (v > hi) begin v = hi; res.sat = 1'b1; end
      if (v < lo) begin v = lo; res.sat = 1'b1; end
      o[c] = v[OUT_W-1:0];
    end
    res.rx = o[0]; res.ry = o[1]; res.rz = o[2];
    return res;
  endfunction

  function automatic logic [CW-1:0] rand_comp(bit unit_scale);
    int sel;
    sel = $urandom_range(0, 9);
    if (!unit_scale || sel == 0) return CW'($urandom);
    if (sel == 1) return '0;
    return CW'($urandom_range(0, 2*ONE) - ONE);
  endfunction

  task automatic push_ray(logic [CW-1:0] ix, iy, iz, nx, ny, nz, eta);
    ray_t t;
    t.ix = ix; t.iy = iy; t.iz = iz; t.nx = nx; t.ny = ny; t.nz = nz; t.eta = eta;
    ray_q.push_back(t);
  endtask

  // Fill the pending queue: directed corners, then random rays
  initial begin
    logic [CW-1:0] mx, mn, one, neg;
    ray_t t;
    mx = {1'b0, {(CW-1){1'b1}}};
    mn = {1'b1, {(CW-1){1'b0}}};
    one = CW'(ONE);
    neg = CW'(-ONE);
    push_ray('0, '0, '0, '0, '0, '0, '0);
    push_ray(neg, '0, '0, one, '0, '0, one);
    push_ray('0, neg, '0, '0, one, '0, CW'(ONE/2));
    push_ray('0, '0, neg, '0, '0, one, CW'(3*ONE/2));
    push_ray(CW'(ONE*7/10), CW'(-ONE*7/10), '0, '0, one, '0, CW'(2*ONE));
    push_ray(mx, mx, mx, mx, mx, mx, '1);
    push_ray(mn, mn, mn, mn, mn, mn, '1);
    push_ray(mx, mn, mx, mn, mx, mn, '1);
    push_ray(mn, mn, mn, mx, mx, mx, '1);
    push_ray(mx, mx, mx, mn, mn, mn, '0);
    push_ray(mn, '0, '0, mn, '0, '0, '1);
    push_ray(mx, '0, '0, '0, '0, '0, '1);
    push_ray('1, '1, '1, '1, '1, '1, '1);
    push_ray(neg, '0, '0, '0, one, '0, CW'(4*ONE));
    push_ray(neg, neg, neg, one, one, one, one);
    push_ray(one, one, one, one, one, one, CW'(ONE/4));
    for (int n = 0; n < 1750; n++) begin
      bit us;
      us = ($urandom_range(0, 3) != 0);
      t.ix = rand_comp(us); t.iy = rand_comp(us); t.iz = rand_comp(us);
      t.nx = rand_comp(us); t.ny = rand_comp(us); t.nz = rand_comp(us);
      t.eta = us ? CW'($urandom_range(0, 3*ONE)) : CW'($urandom);
      ray_q.push_back(t);
    end
  end

  // Reset once, then release
  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Drive rays from the pending queue with random gaps
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_if.valid <= 1'b0;
      item_if.incident_x <= '0; item_if.incident_y <= '0; item_if.incident_z <= '0;
      item_if.normal_x <= '0; item_if.normal_y <= '0; item_if.normal_z <= '0;
      item_if.index_ratio <= '0;
      send_gap = 0;
    end else begin
      if (item_if.valid && item_if.ready) begin
        refr_q.push_back(refract(ray_q.pop_front()));
        send_gap = $urandom_range(0, 3) == 0 ? $urandom_range(0, 15) : 0;
      end
      if (!(item_if.valid && !item_if.ready)) begin
        if (send_gap > 0 || ray_q.size() == 0) begin
          item_if.valid <= 1'b0;
          if (send_gap > 0) send_gap = send_gap - 1;
          if (ray_q.size() == 0) stim_done <= 1'b1;
        end else begin
          item_if.valid <= 1'b1;
          item_if.incident_x <= ray_q[0].ix; item_if.incident_y <= ray_q[0].iy;
          item_if.incident_z <= ray_q[0].iz; item_if.normal_x <= ray_q[0].nx;
          item_if.normal_y <= ray_q[0].ny; item_if.normal_z <= ray_q[0].nz;
          item_if.index_ratio <= ray_q[0].eta;
        end
      end
    end
  end

  // Count the long hold-off of the receiver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_cycles <= 0;
    end else if (cycles >= 300 && hold_cycles < 200) begin
      hold_cycles <= hold_cycles + 1;
    end
  end

  // Accept and check results with random gaps; hold off long once to fill the pipe
  always @(posedge clk_i or negedge rst_ni) begin
    refr_t e;
    if (!rst_ni) begin
      result_if.ready <= 1'b0;
      recv_gap = 0;
    end else begin
      cycles <= cycles + 1;
      if (result_if.valid && result_if.ready) begin
        if (refr_q.size() == 0) begin
          $error("result with no expectation waiting");
          errors++;
        end else begin
          e = refr_q.pop_front();
          if (result_if.refracted_x !== e.rx) begin
            $error("refracted_x exp %h got %h", e.rx, result_if.refracted_x); errors++;
          end
          if (result_if.refracted_y !== e.ry) begin
            $error("refracted_y exp %h got %h", e.ry, result_if.refracted_y); errors++;
          end
          if (result_if.refracted_z !== e.rz) begin
            $error("refracted_z exp %h got %h", e.rz, result_if.refracted_z); errors++;
          end
          if (result_if.total_reflection !== e.tir) begin
            $error("total_reflection exp %b got %b", e.tir,
                   result_if.total_reflection); errors++;
          end
          if (result_if.saturated !== e.sat) begin
            $error("saturated exp %b got %b", e.sat, result_if.saturated); errors++;
          end
        end
        recv_gap = $urandom_range(0, 3) == 0 ? $urandom_range(0, 15) : 0;
      end
      if (cycles >= 300 && hold_cycles < 200) begin
        result_if.ready <= 1'b0;
      end else if (cycles > 20000 && cycles < 24000) begin
        result_if.ready <= 1'b1;
      end else if (recv_gap > 0) begin
        recv_gap = recv_gap - 1;
        result_if.ready <= 1'b0;
      end else begin
        result_if.ready <= 1'b1;
      end
    end
  end

  // End of run: drain, settle, report
  initial begin
    fork
      begin
        wait (stim_done && refr_q.size() == 0);
        repeat (PIPE_DEPTH + 20) @(posedge clk_i);
        if (errors == 0) begin
          $display("TEST PASSED");
        end else begin
          $display("TEST FAILED");
        end
      end
      begin
        wait (cycles >= 200000);
        $display("TEST FAILED");
      end
    join_any
    $finish;
  end
endmodule

/* vector_refract_core.f */
src/vrf_pkg.sv
src/vrf_if.sv
src/vrf_front.sv
src/vrf_sqrt_cell.sv
src/vrf_back.sv
src/vector_refract_core.sv
src/vrf_checker.sv
sim/tb_vector_refract_core.sv
